// ===== sv/primitive_vertex_assembler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Primitive vertex assembler assertion macros
// Shared concurrent assertion forms used by the assembler modules.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_VERTEX_ASSEMBLER_TOP_ASSERT_SVH
`define PRIMITIVE_VERTEX_ASSEMBLER_TOP_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define PVA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define PVA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// Primitive vertex assembler package
// Types and constants shared by the assembler front end, queue and back end.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_KICK   = 2'd1,
        KIND_NOKICK = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PRIM_POINT  = 3'd0,
        PRIM_LINE   = 3'd1,
        PRIM_LSTRIP = 3'd2,
        PRIM_TRI    = 3'd3,
        PRIM_TSTRIP = 3'd4,
        PRIM_FAN    = 3'd5,
        PRIM_SPRITE = 3'd6,
        PRIM_BAD    = 3'd7
    } prim_t;

    typedef enum logic {
        REG_USE_PRIM = 1'b0,
        REG_MODE     = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] pos_z;
        logic [63:0] color_q;
        logic [63:0] tex_st;
        logic [9:0]  tex_u;
        logic [9:0]  tex_v;
        logic [7:0]  fog;
    } vertex_t;

    // One primitive to emit: up to three vertices plus shared fields.
    typedef struct packed {
        vertex_t [2:0] vtx;
        logic [1:0]    num;
        logic [2:0]    prim_type;
        logic [7:0]    attr;
        logic          bad;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  prim_type;
        vertex_t     vtx;
        logic [7:0]  attr;
        logic        bad_prim;
        logic        last_vertex;
    } result_t;

endpackage

// ===== sv/pva_if.sv =====
// ----------------------------------------------------------------------------
// Primitive vertex assembler channels
// Valid/ready interfaces for input items and emitted vertex results.
// ----------------------------------------------------------------------------
interface pva_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [10:0] prim_word;
    logic [63:0] xyz_word;
    logic [63:0] rgbaq_word;
    logic [63:0] st_word;
    logic [29:0] uv_word;
    logic [7:0]  fog_value;

    modport source (output valid, kind, prim_word, xyz_word, rgbaq_word, st_word,
                    uv_word, fog_value, input ready);
    modport sink (input valid, kind, prim_word, xyz_word, rgbaq_word, st_word,
                  uv_word, fog_value, output ready);
endinterface

interface pva_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  prim_type;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [31:0] pos_z;
    logic [63:0] color_q;
    logic [63:0] tex_st;
    logic [9:0]  tex_u;
    logic [9:0]  tex_v;
    logic [7:0]  fog_out;
    logic [7:0]  attr_flags;
    logic        bad_prim;
    logic        last_vertex;

    modport source (output valid, prim_type, pos_x, pos_y, pos_z, color_q, tex_st,
                    tex_u, tex_v, fog_out, attr_flags, bad_prim, last_vertex,
                    input ready);
    modport sink (input valid, prim_type, pos_x, pos_y, pos_z, color_q, tex_st,
                  tex_u, tex_v, fog_out, attr_flags, bad_prim, last_vertex,
                  output ready);
endinterface

// ===== sv/pva_front.sv =====
// ----------------------------------------------------------------------------
// Primitive vertex assembler front end
// Accepts items, keeps the vertex queue and builds one command per primitive.
// ----------------------------------------------------------------------------
`include "primitive_vertex_assembler_top_assert.svh"

module pva_front
    import pva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pva_in_if.sink      in_ch,
    input  logic        use_prim_attr,
    input  logic [10:0] mode_attr,
    output cmd_t        cmd,
    output logic        cmd_push,
    input  logic        cmd_full
);

    vertex_t     vtx_reg [QDEPTH];
    vertex_t     vtx_next [QDEPTH];
    vertex_t     upd [QDEPTH];
    vertex_t     new_vtx;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [10:0] prim_reg;
    logic [10:0] attr_word;
    prim_t       ptype;
    logic [1:0]  slot;
    logic [2:0]  n;
    logic [1:0]  sel0, sel1, sel2;
    logic [1:0]  emit_num;
    logic        accept;
    logic        is_vertex;
    logic        is_bad;

    assign in_ch.ready = !cmd_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_vertex   = (in_ch.kind == KIND_KICK) || (in_ch.kind == KIND_NOKICK);
    assign ptype       = prim_t'(prim_reg[2:0]);
    assign is_bad      = (ptype == PRIM_BAD);
    assign attr_word   = use_prim_attr ? prim_reg : mode_attr;
    assign slot        = count_reg[1:0];
    assign n           = {1'b0, slot} + 3'd1;

    // Fixed-point positions and texel coordinates keep their integer parts.
    always_comb
    begin
        new_vtx.pos_x   = in_ch.xyz_word[15:4];
        new_vtx.pos_y   = in_ch.xyz_word[31:20];
        new_vtx.pos_z   = in_ch.xyz_word[63:32];
        new_vtx.color_q = in_ch.rgbaq_word;
        new_vtx.tex_st  = in_ch.st_word;
        new_vtx.tex_u   = in_ch.uv_word[13:4];
        new_vtx.tex_v   = in_ch.uv_word[29:20];
        new_vtx.fog     = in_ch.fog_value;
    end

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            upd[i] = (slot == 2'(i)) ? new_vtx : vtx_reg[i];
        end
    end

    always_comb
    begin
        vtx_next   = upd;
        count_next = n;
        sel0       = 2'd0;
        sel1       = 2'd1;
        sel2       = 2'd2;
        emit_num   = 2'd0;
        case (ptype)
            PRIM_POINT:
            begin
                if (n == 3'd1)
                begin
                    emit_num   = 2'd1;
                    count_next = 3'd0;
                end
            end
            PRIM_LINE, PRIM_SPRITE:
            begin
                if (n == 3'd2)
                begin
                    emit_num   = 2'd2;
                    count_next = 3'd0;
                end
            end
            PRIM_LSTRIP:
            begin
                if (n == 3'd2)
                begin
                    emit_num = 2'd2;
                end
                else if (n == 3'd3)
                begin
                    emit_num    = 2'd2;
                    sel0        = 2'd1;
                    sel1        = 2'd2;
                    vtx_next[0] = upd[1];
                    vtx_next[1] = upd[2];
                    count_next  = 3'd2;
                end
            end
            PRIM_TRI:
            begin
                if (n == 3'd3)
                begin
                    emit_num   = 2'd3;
                    count_next = 3'd0;
                end
            end
            PRIM_TSTRIP:
            begin
                if (n == 3'd3)
                begin
                    emit_num = 2'd3;
                end
                else if (n == 3'd4)
                begin
                    emit_num    = 2'd3;
                    sel0        = 2'd1;
                    sel1        = 2'd2;
                    sel2        = 2'd3;
                    vtx_next[0] = upd[1];
                    vtx_next[1] = upd[2];
                    vtx_next[2] = upd[3];
                    count_next  = 3'd3;
                end
            end
            PRIM_FAN:
            begin
                if (n == 3'd3)
                begin
                    emit_num = 2'd3;
                end
                else if (n == 3'd4)
                begin
                    // The fan center stays in entry zero.
                    emit_num    = 2'd3;
                    sel1        = 2'd2;
                    sel2        = 2'd3;
                    vtx_next[1] = upd[2];
                    vtx_next[2] = upd[3];
                    count_next  = 3'd3;
                end
            end
            default:
            begin
                // Reserved type: the vertex is dropped and the queue emptied.
                vtx_next   = vtx_reg;
                count_next = 3'd0;
            end
        endcase
        if (count_next == 3'(QDEPTH))
        begin
            count_next = 3'd0;
        end
    end

    always_comb
    begin
        if (is_bad)
        begin
            cmd.vtx       = '0;
            cmd.num       = 2'd1;
            cmd.prim_type = PRIM_BAD;
            cmd.attr      = 8'd0;
            cmd.bad       = 1'b1;
        end
        else
        begin
            cmd.vtx[0]    = upd[sel0];
            cmd.vtx[1]    = upd[sel1];
            cmd.vtx[2]    = upd[sel2];
            cmd.num       = emit_num;
            cmd.prim_type = prim_reg[2:0];
            cmd.attr      = attr_word[10:3];
            cmd.bad       = 1'b0;
        end
    end

    assign cmd_push = accept && is_vertex &&
                      (is_bad || ((in_ch.kind == KIND_KICK) && (emit_num != 2'd0)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            prim_reg  <= 11'd0;
        end
        else if (accept)
        begin
            if (in_ch.kind == KIND_SET)
            begin
                prim_reg  <= in_ch.prim_word;
                count_reg <= 3'd0;
            end
            else if (is_vertex)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_vertex)
        begin
            vtx_reg <= vtx_next;
        end
    end

    `PVA_ASSERT(a_push_room, clk, rst_n, cmd_push |-> !cmd_full, "command pushed into full queue")
    `PVA_ASSERT(a_set_clears, clk, rst_n, (accept && in_ch.kind == KIND_SET) |=> count_reg == 3'd0, "primitive set did not empty the vertex queue")
    `PVA_NEVER(a_count_range, clk, rst_n, count_reg > 3'd3, "vertex count beyond queue depth")

endmodule

// ===== sv/pva_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Primitive vertex assembler command queue
// Short first-in first-out queue of primitive commands between front and back.
// ----------------------------------------------------------------------------
module pva_cmd_fifo
    import pva_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    input  logic pop,
    output cmd_t dout,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== sv/pva_back.sv =====
// ----------------------------------------------------------------------------
// Primitive vertex assembler back end
// Walks each queued command and emits its vertices, one result per cycle while the receiver accepts them.
// ----------------------------------------------------------------------------
`include "primitive_vertex_assembler_top_assert.svh"

module pva_back
    import pva_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   head,
    input  logic   fifo_empty,
    output logic   pop,
    pva_out_if.source out_ch
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       load;
    logic       last;

    assign load = !fifo_empty && (!out_valid_reg || out_ch.ready);
    assign last = (idx_reg == 2'(head.num - 2'd1));
    assign pop  = load && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        res_next.prim_type   = head.prim_type;
        res_next.vtx         = head.vtx[idx_reg];
        res_next.attr        = head.attr;
        res_next.bad_prim    = head.bad;
        res_next.last_vertex = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.prim_type   = res_reg.prim_type;
    assign out_ch.pos_x       = res_reg.vtx.pos_x;
    assign out_ch.pos_y       = res_reg.vtx.pos_y;
    assign out_ch.pos_z       = res_reg.vtx.pos_z;
    assign out_ch.color_q     = res_reg.vtx.color_q;
    assign out_ch.tex_st      = res_reg.vtx.tex_st;
    assign out_ch.tex_u       = res_reg.vtx.tex_u;
    assign out_ch.tex_v       = res_reg.vtx.tex_v;
    assign out_ch.fog_out     = res_reg.vtx.fog;
    assign out_ch.attr_flags  = res_reg.attr;
    assign out_ch.bad_prim    = res_reg.bad_prim;
    assign out_ch.last_vertex = res_reg.last_vertex;

    `PVA_ASSERT(a_idx_range, clk, rst_n, !fifo_empty |-> (idx_reg < head.num), "vertex index past end of command")
    `PVA_ASSERT(a_pop_restart, clk, rst_n, pop |=> idx_reg == 2'd0, "vertex index not reset after command")
    `PVA_ASSERT(a_bad_single, clk, rst_n, (out_valid_reg && res_reg.bad_prim) |-> res_reg.last_vertex, "error result not marked last")

endmodule

// ===== sv/primitive_vertex_assembler_top.sv =====
// ----------------------------------------------------------------------------
// Primitive vertex assembler top level
// Configuration registers and the front end, command queue and back end.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle while the command queue has room;
// set-primitive items and vertices that complete nothing push no command. The
// back end emits one vertex result per cycle while the receiver is ready, so a
// completed primitive yields as many results as it has vertices: one for a
// point or error result, two for a line, line-strip step or sprite, and three
// for a triangle, triangle-strip or fan step. Results leave through a
// registered output; the command queue lets the front end keep accepting
// while results are stalled, until the queue fills.
module primitive_vertex_assembler_top
    import pva_pkg::*;
#(
    parameter int CMD_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pva_in_if.sink      in_ch,
    pva_out_if.source   out_ch
);

    logic        use_prim_reg;
    logic [10:0] mode_attr_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    cmd_t        cmd;
    cmd_t        head;
    logic        cmd_push;
    logic        cmd_pop;
    logic        cmd_full;
    logic        cmd_empty;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_prim_reg  <= 1'b0;
            mode_attr_reg <= 11'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_USE_PRIM: use_prim_reg  <= pwdata[0];
                REG_MODE:     mode_attr_reg <= pwdata[10:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_USE_PRIM: prdata = {31'd0, use_prim_reg};
            REG_MODE:     prdata = {21'd0, mode_attr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    pva_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .use_prim_attr (use_prim_reg),
        .mode_attr     (mode_attr_reg),
        .cmd           (cmd),
        .cmd_push      (cmd_push),
        .cmd_full      (cmd_full)
    );

    pva_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd),
        .pop   (cmd_pop),
        .dout  (head),
        .full  (cmd_full),
        .empty (cmd_empty)
    );

    pva_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (cmd_empty),
        .pop        (cmd_pop),
        .out_ch     (out_ch)
    );

endmodule

// ===== verif/pva_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Primitive vertex assembler stream checker
// Follows register writes and both item channels. For every accepted input
// item it predicts the vertex results of the assembler and compares each
// emitted result, in order, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pva_stream_checker
    import pva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    pva_in_if           in_ch,
    pva_out_if          out_ch,
    output int unsigned n_errors,
    output int unsigned n_pending
);

    localparam int unsigned MAX_REPORTS = 40;

    vertex_t     vq [QDEPTH];
    int unsigned vq_count;
    logic [10:0] cur_prim;
    logic        use_prim_attr;
    logic [10:0] mode_attr;
    result_t     expected_vertices [$];

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        if (n_errors < MAX_REPORTS)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic queue_run(input int unsigned i0, i1, i2, input int unsigned n,
                             input bit kick, input logic [7:0] attr);
        int unsigned sel [3];
        result_t     r;
        sel = '{i0, i1, i2};
        if (kick)
        begin
            for (int k = 0; k < n; k++)
            begin
                r.prim_type   = cur_prim[2:0];
                r.vtx         = vq[sel[k]];
                r.attr        = attr;
                r.bad_prim    = 1'b0;
                r.last_vertex = (k == n - 1);
                expected_vertices.push_back(r);
            end
        end
    endtask

    task automatic predict(input kind_t kind, input logic [10:0] prim_word,
                           input logic [63:0] xyz, rgbaq, st,
                           input logic [29:0] uv, input logic [7:0] fog);
        bit          kick;
        prim_t       ptype;
        logic [7:0]  attr;
        int unsigned slot;
        int unsigned n;
        result_t     err;
        if (kind == KIND_SET)
        begin
            cur_prim = prim_word;
            vq_count = 0;
            return;
        end
        if (kind == KIND_NONE)
            return;

        kick  = (kind == KIND_KICK);
        ptype = prim_t'(cur_prim[2:0]);
        attr  = use_prim_attr ? cur_prim[10:3] : mode_attr[10:3];

        // A reserved type drops the vertex and flushes the queue, kick or not.
        if (ptype == PRIM_BAD)
        begin
            err             = '0;
            err.prim_type   = PRIM_BAD;
            err.bad_prim    = 1'b1;
            err.last_vertex = 1'b1;
            expected_vertices.push_back(err);
            vq_count = 0;
            return;
        end

        slot               = vq_count % QDEPTH;
        vq[slot].pos_x     = xyz[15:4];
        vq[slot].pos_y     = xyz[31:20];
        vq[slot].pos_z     = xyz[63:32];
        vq[slot].color_q   = rgbaq;
        vq[slot].tex_st    = st;
        vq[slot].tex_u     = uv[13:4];
        vq[slot].tex_v     = uv[29:20];
        vq[slot].fog       = fog;
        n                  = slot + 1;
        vq_count           = n;

        case (ptype)
            PRIM_POINT:
            begin
                if (n == 1)
                begin
                    queue_run(0, 0, 0, 1, kick, attr);
                    vq_count = 0;
                end
            end
            PRIM_LINE, PRIM_SPRITE:
            begin
                if (n == 2)
                begin
                    queue_run(0, 1, 0, 2, kick, attr);
                    vq_count = 0;
                end
            end
            PRIM_LSTRIP:
            begin
                if (n == 2)
                    queue_run(0, 1, 0, 2, kick, attr);
                else if (n == 3)
                begin
                    queue_run(1, 2, 0, 2, kick, attr);
                    vq[0]    = vq[1];
                    vq[1]    = vq[2];
                    vq_count = 2;
                end
            end
            PRIM_TRI:
            begin
                if (n == 3)
                begin
                    queue_run(0, 1, 2, 3, kick, attr);
                    vq_count = 0;
                end
            end
            PRIM_TSTRIP:
            begin
                if (n == 3)
                    queue_run(0, 1, 2, 3, kick, attr);
                else if (n == 4)
                begin
                    queue_run(1, 2, 3, 3, kick, attr);
                    vq[0]    = vq[1];
                    vq[1]    = vq[2];
                    vq[2]    = vq[3];
                    vq_count = 3;
                end
            end
            default:
            begin
                // Fan: the first vertex stays as the hub.
                if (n == 3)
                    queue_run(0, 1, 2, 3, kick, attr);
                else if (n == 4)
                begin
                    queue_run(0, 2, 3, 3, kick, attr);
                    vq[1]    = vq[2];
                    vq[2]    = vq[3];
                    vq_count = 3;
                end
            end
        endcase

        if (vq_count >= QDEPTH)
            vq_count = 0;
    endtask

    task automatic compare_result(input result_t want);
        if (out_ch.prim_type !== want.prim_type)
            report("prim_type", out_ch.prim_type, want.prim_type);
        if (out_ch.pos_x !== want.vtx.pos_x)
            report("pos_x", out_ch.pos_x, want.vtx.pos_x);
        if (out_ch.pos_y !== want.vtx.pos_y)
            report("pos_y", out_ch.pos_y, want.vtx.pos_y);
        if (out_ch.pos_z !== want.vtx.pos_z)
            report("pos_z", out_ch.pos_z, want.vtx.pos_z);
        if (out_ch.color_q !== want.vtx.color_q)
            report("color_q", out_ch.color_q, want.vtx.color_q);
        if (out_ch.tex_st !== want.vtx.tex_st)
            report("tex_st", out_ch.tex_st, want.vtx.tex_st);
        if (out_ch.tex_u !== want.vtx.tex_u)
            report("tex_u", out_ch.tex_u, want.vtx.tex_u);
        if (out_ch.tex_v !== want.vtx.tex_v)
            report("tex_v", out_ch.tex_v, want.vtx.tex_v);
        if (out_ch.fog_out !== want.vtx.fog)
            report("fog_out", out_ch.fog_out, want.vtx.fog);
        if (out_ch.attr_flags !== want.attr)
            report("attr_flags", out_ch.attr_flags, want.attr);
        if (out_ch.bad_prim !== want.bad_prim)
            report("bad_prim", out_ch.bad_prim, want.bad_prim);
        if (out_ch.last_vertex !== want.last_vertex)
            report("last_vertex", out_ch.last_vertex, want.last_vertex);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_count      = 0;
            cur_prim      = '0;
            use_prim_attr = 1'b0;
            mode_attr     = '0;
            expected_vertices.delete();
            n_pending     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_USE_PRIM: use_prim_attr = pwdata[0];
                    REG_MODE:     mode_attr     = pwdata[10:0];
                    default:      ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_vertices.size() == 0)
                    report("result with nothing expected, color_q", out_ch.color_q, '0);
                else
                    compare_result(expected_vertices.pop_front());
            end
            if (in_ch.valid && in_ch.ready)
                predict(kind_t'(in_ch.kind), in_ch.prim_word, in_ch.xyz_word,
                        in_ch.rgbaq_word, in_ch.st_word, in_ch.uv_word, in_ch.fog_value);
            n_pending = expected_vertices.size();
        end
    end

endmodule

// ===== verif/primitive_vertex_assembler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Primitive vertex assembler testbench
// Drives directed primitives of every type, then random primitive sequences
// under several attribute settings, with random gaps on both channels, a
// long output stall and drain pauses. The stream checker judges the results.
// ----------------------------------------------------------------------------
module primitive_vertex_assembler_top_tb;
    import pva_pkg::*;

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 300;

    typedef enum {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct {
        kind_t       kind;
        logic [10:0] prim_word;
        logic [63:0] xyz;
        logic [63:0] rgbaq;
        logic [63:0] st;
        logic [29:0] uv;
        logic [7:0]  fog;
    } item_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned n_errors;
    int unsigned n_pending;
    int unsigned send_gap_max = 11;
    int unsigned recv_gap_max = 11;
    int unsigned hold_cycles  = 0;
    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;

    pva_in_if  in_ch ();
    pva_out_if out_ch ();

    primitive_vertex_assembler_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    pva_stream_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result receiver: random hold-offs, plus one long stall on request.
    initial
    begin
        int unsigned idle;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
            begin
                idle = $urandom_range(0, recv_gap_max);
                if (idle > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (idle) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
                do @(posedge clk); while (!out_ch.valid);
            end
        end
    end

    function automatic item_t vertex_item(input kind_t kind, input fill_t fill);
        item_t it;
        it.kind      = kind;
        it.prim_word = 11'($urandom);
        case (fill)
            FILL_ZERO:
            begin
                it.xyz   = '0;
                it.rgbaq = '0;
                it.st    = '0;
                it.uv    = '0;
                it.fog   = '0;
            end
            FILL_ONES:
            begin
                it.xyz   = '1;
                it.rgbaq = '1;
                it.st    = '1;
                it.uv    = '1;
                it.fog   = '1;
            end
            default:
            begin
                it.xyz   = {$urandom, $urandom};
                it.rgbaq = {$urandom, $urandom};
                it.st    = {$urandom, $urandom};
                it.uv    = 30'($urandom);
                it.fog   = 8'($urandom);
            end
        endcase
        return it;
    endfunction

    function automatic item_t set_item(input prim_t ptype, input logic [7:0] attr);
        item_t it;
        it           = vertex_item(KIND_SET, FILL_RANDOM);
        it.prim_word = {attr, ptype};
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= it.kind;
        in_ch.prim_word  <= it.prim_word;
        in_ch.xyz_word   <= it.xyz;
        in_ch.rgbaq_word <= it.rgbaq;
        in_ch.st_word    <= it.st;
        in_ch.uv_word    <= it.uv;
        in_ch.fog_value  <= it.fog;
        do @(posedge clk); while (!in_ch.ready);
        if (it.kind != KIND_NONE)
            items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has left.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input bit use_prim, input logic [10:0] mode);
        write_reg(REG_USE_PRIM, {31'b0, use_prim});
        write_reg(REG_MODE, {21'b0, mode});
    endtask

    // Mostly well-formed primitive sequences with random content; a stray
    // primitive change mid-sequence or an idle kind acts as noise.
    task automatic run_sequences(input int unsigned count);
        int unsigned stop_at;
        int unsigned n_vtx;
        int unsigned pick;
        prim_t       ptype;
        kind_t       kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    ptype = PRIM_BAD;
                else
                    ptype = prim_t'($urandom_range(0, 6));
                send_item(set_item(ptype, 8'($urandom)));
            end
            n_vtx = $urandom_range(1, 8);
            repeat (n_vtx)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    kind = KIND_KICK;
                else if (pick < 96)
                    kind = KIND_NOKICK;
                else
                    kind = KIND_NONE;
                send_item(vertex_item(kind, FILL_RANDOM));
            end
        end
    endtask

    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_SET;
        in_ch.prim_word  <= '0;
        in_ch.xyz_word   <= '0;
        in_ch.rgbaq_word <= '0;
        in_ch.st_word    <= '0;
        in_ch.uv_word    <= '0;
        in_ch.fog_value  <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every primitive type, field extremes, no-kick and idle kinds.
        configure(1'b1, 11'h000);
        send_item(set_item(PRIM_POINT, 8'hff));
        send_item(vertex_item(KIND_KICK, FILL_ONES));
        send_item(set_item(PRIM_LINE, 8'h00));
        send_item(vertex_item(KIND_KICK, FILL_ZERO));
        send_item(vertex_item(KIND_KICK, FILL_ONES));
        send_item(set_item(PRIM_LSTRIP, 8'ha5));
        send_item(vertex_item(KIND_NOKICK, FILL_ONES));
        send_item(vertex_item(KIND_KICK, FILL_RANDOM));
        send_item(vertex_item(KIND_KICK, FILL_RANDOM));
        send_item(set_item(PRIM_TRI, 8'h5a));
        send_item(vertex_item(KIND_KICK, FILL_ZERO));
        send_item(vertex_item(KIND_KICK, FILL_ONES));
        send_item(vertex_item(KIND_KICK, FILL_RANDOM));
        send_item(set_item(PRIM_TSTRIP, 8'h3c));
        repeat (4) send_item(vertex_item(KIND_KICK, FILL_RANDOM));
        send_item(set_item(PRIM_FAN, 8'hc3));
        send_item(vertex_item(KIND_NOKICK, FILL_RANDOM));
        repeat (3) send_item(vertex_item(KIND_KICK, FILL_RANDOM));
        send_item(set_item(PRIM_SPRITE, 8'h81));
        repeat (2) send_item(vertex_item(KIND_KICK, FILL_RANDOM));
        send_item(set_item(PRIM_BAD, 8'hff));
        send_item(vertex_item(KIND_KICK, FILL_RANDOM));
        send_item(vertex_item(KIND_NOKICK, FILL_RANDOM));
        send_item(vertex_item(KIND_NONE, FILL_ONES));
        wait_drained();

        configure(1'b0, 11'h7ff);
        run_sequences(60);
        wait_drained();

        // The receiver stalls for a long stretch while items keep coming.
        configure(1'b0, 11'h000);
        send_gap_max = 0;
        hold_cycles  = LONG_HOLD;
        run_sequences(70);
        wait_drained();

        configure(1'b1, 11'($urandom_range(0, 2047)));
        recv_gap_max = 0;
        run_sequences(35);
        wait_drained();
        run_sequences(35);
        wait_drained();

        configure(1'b0, 11'($urandom_range(0, 2047)));
        send_gap_max = 11;
        run_sequences(70);
        wait_drained();

        configure(1'b1, 11'h7ff);
        send_gap_max = 4;
        recv_gap_max = 11;
        run_sequences(70);
        wait_drained();

        if (n_errors == 0 && n_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
